### hw/rtl/tcpf_pkg.sv
// Shared constants, codes and command types of the track closest point finder.
`default_nettype none
package tcpf_pkg;

	localparam int COORD_BITS    = 24;
	localparam int DIFF_BITS     = COORD_BITS + 1;
	localparam int DSQ_BITS      = 2 * DIFF_BITS;
	localparam int DIST_BITS     = COORD_BITS + 1;
	localparam int ROOT_REM_BITS = DIST_BITS + 2;
	localparam int ROOT_STEPS    = DIST_BITS;
	localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS);
	localparam int CFG_IDX_BITS  = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X   = 3'd3,
		REG_END_Y   = 3'd4,
		REG_END_Z   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic  load;       // take a new point, square its x differences
		logic  mul;        // square the differences on axis
		axis_t axis;
		logic  update;     // finish the sums, keep the smaller distance
		logic  root_load;  // start square roots of the kept minima
		logic  root_step;  // one root digit
		logic  out_load;   // fill the result register, clear minima
	} dp_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/tcpf_isqrt.sv
// Digit-by-digit integer square root, one result bit per step.
`default_nettype none
module tcpf_isqrt
	import tcpf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic                 step,
	input  wire logic [DSQ_BITS-1:0]  radicand,
	output logic      [DIST_BITS-1:0] root
);

	logic [DSQ_BITS-1:0]      rad_q;
	logic [ROOT_REM_BITS-1:0] rem_q;
	logic [DIST_BITS-1:0]     root_q;
	logic [ROOT_REM_BITS-1:0] rem_sh;
	logic [ROOT_REM_BITS-1:0] trial;
	logic                     fits;

	// remainder stays below 2*root, so the shifted value fits
	assign rem_sh = {rem_q[ROOT_REM_BITS-3:0], rad_q[DSQ_BITS-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			rad_q  <= {rad_q[DSQ_BITS-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[DIST_BITS-2:0], fits};
		end
	end

	assign root = root_q;

endmodule
`default_nettype wire

### hw/rtl/tcpf_dpath.sv
// Datapath: reference registers, squared distances, running minima, roots, result register.
`default_nettype none
module tcpf_dpath
	import tcpf_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [COORD_BITS-1:0]         cfg_data,
	input  wire dp_cmd_t                       cmd,
	input  wire logic signed [COORD_BITS-1:0]  step_x,
	input  wire logic signed [COORD_BITS-1:0]  step_y,
	input  wire logic signed [COORD_BITS-1:0]  step_z,
	output logic signed [COORD_BITS-1:0]       near_start_x,
	output logic signed [COORD_BITS-1:0]       near_start_y,
	output logic signed [COORD_BITS-1:0]       near_start_z,
	output logic        [DIST_BITS-1:0]        start_distance,
	output logic signed [COORD_BITS-1:0]       near_end_x,
	output logic signed [COORD_BITS-1:0]       near_end_y,
	output logic signed [COORD_BITS-1:0]       near_end_z,
	output logic        [DIST_BITS-1:0]        end_distance
);

	function automatic logic [DSQ_BITS-1:0] sq_diff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		logic [DIFF_BITS-1:0] d;
		logic [DIFF_BITS-1:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[DIFF_BITS-1] ? DIFF_BITS'(~d + 1'b1) : d;
		return DSQ_BITS'(m) * DSQ_BITS'(m);
	endfunction

	logic [COORD_BITS-1:0] ref_s_q [3];
	logic [COORD_BITS-1:0] ref_e_q [3];
	logic [COORD_BITS-1:0] pt_q    [3];
	logic [COORD_BITS-1:0] best_s_pt_q [3];
	logic [COORD_BITS-1:0] best_e_pt_q [3];
	logic [DSQ_BITS-1:0]   best_s_q, best_e_q;
	logic [DSQ_BITS-1:0]   prod_s_q, prod_e_q;
	logic [DSQ_BITS-1:0]   acc_s_q, acc_e_q;
	logic [DSQ_BITS-1:0]   dsq_s, dsq_e;
	logic [COORD_BITS-1:0] op_pt, op_rs, op_re;
	logic [DIST_BITS-1:0]  root_s, root_e;
	logic [COORD_BITS-1:0] out_s_q [3];
	logic [COORD_BITS-1:0] out_e_q [3];
	logic [DIST_BITS-1:0]  out_sd_q, out_ed_q;

	// configuration, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ref_s_q[i] <= '0;
				ref_e_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X: ref_s_q[0] <= cfg_data;
				REG_START_Y: ref_s_q[1] <= cfg_data;
				REG_START_Z: ref_s_q[2] <= cfg_data;
				REG_END_X:   ref_e_q[0] <= cfg_data;
				REG_END_Y:   ref_e_q[1] <= cfg_data;
				REG_END_Z:   ref_e_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select: x from the ports on load, y or z from the held point
	always_comb begin
		op_pt = step_x;
		op_rs = ref_s_q[0];
		op_re = ref_e_q[0];
		if (!cmd.load) begin
			unique case (cmd.axis)
				AXIS_Y: begin
					op_pt = pt_q[1];
					op_rs = ref_s_q[1];
					op_re = ref_e_q[1];
				end
				AXIS_Z: begin
					op_pt = pt_q[2];
					op_rs = ref_s_q[2];
					op_re = ref_e_q[2];
				end
				default: begin
					op_pt = pt_q[0];
					op_rs = ref_s_q[0];
					op_re = ref_e_q[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_q[0] <= step_x;
			pt_q[1] <= step_y;
			pt_q[2] <= step_z;
		end
		if (cmd.load || cmd.mul) begin
			prod_s_q <= sq_diff(op_pt, op_rs);
			prod_e_q <= sq_diff(op_pt, op_re);
		end
		if (cmd.mul) begin
			acc_s_q <= (cmd.axis == AXIS_Y) ? prod_s_q : acc_s_q + prod_s_q;
			acc_e_q <= (cmd.axis == AXIS_Y) ? prod_e_q : acc_e_q + prod_e_q;
		end
	end

	assign dsq_s = acc_s_q + prod_s_q;
	assign dsq_e = acc_e_q + prod_e_q;

	// running minima; strict compare keeps the earliest point on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_s_q <= '1;
			best_e_q <= '1;
			for (int i = 0; i < 3; i++) begin
				best_s_pt_q[i] <= '0;
				best_e_pt_q[i] <= '0;
			end
		end else if (cmd.out_load) begin
			best_s_q <= '1;
			best_e_q <= '1;
			for (int i = 0; i < 3; i++) begin
				best_s_pt_q[i] <= '0;
				best_e_pt_q[i] <= '0;
			end
		end else if (cmd.update) begin
			if (dsq_s < best_s_q) begin
				best_s_q    <= dsq_s;
				best_s_pt_q <= pt_q;
			end
			if (dsq_e < best_e_q) begin
				best_e_q    <= dsq_e;
				best_e_pt_q <= pt_q;
			end
		end
	end

	tcpf_isqrt u_root_s (
		.clk      (clk),
		.load     (cmd.root_load),
		.step     (cmd.root_step),
		.radicand (best_s_q),
		.root     (root_s)
	);

	tcpf_isqrt u_root_e (
		.clk      (clk),
		.load     (cmd.root_load),
		.step     (cmd.root_step),
		.radicand (best_e_q),
		.root     (root_e)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_s_q  <= best_s_pt_q;
			out_e_q  <= best_e_pt_q;
			out_sd_q <= root_s;
			out_ed_q <= root_e;
		end
	end

	assign near_start_x   = out_s_q[0];
	assign near_start_y   = out_s_q[1];
	assign near_start_z   = out_s_q[2];
	assign start_distance = out_sd_q;
	assign near_end_x     = out_e_q[0];
	assign near_end_y     = out_e_q[1];
	assign near_end_z     = out_e_q[2];
	assign end_distance   = out_ed_q;

endmodule
`default_nettype wire

### hw/rtl/tcpf_ctrl.sv
// Controller: sequences the per-point distance steps, the roots and the result handshake.
`default_nettype none
module tcpf_ctrl
	import tcpf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic last_step,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output dp_cmd_t   cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_MUL_Y   = 7'b0000010,
		S_MUL_Z   = 7'b0000100,
		S_CMP     = 7'b0001000,
		S_ROOT_LD = 7'b0010000,
		S_ROOT    = 7'b0100000,
		S_EMIT    = 7'b1000000
	} ctrl_state_t;

	ctrl_state_t              state_q, state_d;
	logic                     last_q;
	logic                     out_valid_q;
	logic [ROOT_CNT_BITS-1:0] cnt_q;
	logic                     accept;
	logic                     out_free;

	assign in_stall = !((state_q == S_IDLE) || ((state_q == S_CMP) && !last_q));
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.axis = AXIS_X;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL_Y;
				end
			end
			S_MUL_Y: begin
				cmd.mul  = 1'b1;
				cmd.axis = AXIS_Y;
				state_d  = S_MUL_Z;
			end
			S_MUL_Z: begin
				cmd.mul  = 1'b1;
				cmd.axis = AXIS_Z;
				state_d  = S_CMP;
			end
			S_CMP: begin
				cmd.update = 1'b1;
				if (last_q) begin
					state_d = S_ROOT_LD;
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL_Y;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ROOT_LD: begin
				cmd.root_load = 1'b1;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == ROOT_CNT_BITS'(ROOT_STEPS - 1)) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last_step;
			end
			if (cmd.root_load) begin
				cnt_q <= '0;
			end else if (cmd.root_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hw/rtl/track_closest_point_finder_top.sv
// Top level of the track closest point finder: controller, datapath and checks.
`default_nettype none
// Track closest point finder. Points of one track arrive one per input
// transaction; for each of the two reference points (start, end) set through
// the write port, the block keeps the point with the smallest squared
// Euclidean distance, taking only a strictly smaller one so the earliest point
// wins ties. The point flagged last_step also takes part; after it the block
// produces one result transaction with both closest points and the floor square
// roots of their squared distances, then clears its minima for the next track.
// Sequence: x difference squared at accept, then y, then z, then the sum and
// compare; the next point is taken in the compare cycle. Two 25x25 squarers,
// one per reference, serve all three axes in turn. A last point then goes
// through the root load, the root steps (one bit per cycle, both roots in
// parallel) and the fill of the result register, which lets the next track
// start while a result waits. Coordinates are signed with 4 fractional bits;
// distances are in the same 1/16 unit. Write the references only while idle.
module track_closest_point_finder_top
	import tcpf_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [COORD_BITS-1:0]         cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_BITS-1:0]  step_x,
	input  wire logic signed [COORD_BITS-1:0]  step_y,
	input  wire logic signed [COORD_BITS-1:0]  step_z,
	input  wire logic                          last_step,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_BITS-1:0]       near_start_x,
	output logic signed [COORD_BITS-1:0]       near_start_y,
	output logic signed [COORD_BITS-1:0]       near_start_z,
	output logic        [DIST_BITS-1:0]        start_distance,
	output logic signed [COORD_BITS-1:0]       near_end_x,
	output logic signed [COORD_BITS-1:0]       near_end_y,
	output logic signed [COORD_BITS-1:0]       near_end_z,
	output logic        [DIST_BITS-1:0]        end_distance
);

	dp_cmd_t cmd;

	tcpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_step (last_step),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tcpf_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.step_x         (step_x),
		.step_y         (step_y),
		.step_z         (step_z),
		.near_start_x   (near_start_x),
		.near_start_y   (near_start_y),
		.near_start_z   (near_start_z),
		.start_distance (start_distance),
		.near_end_x     (near_end_x),
		.near_end_y     (near_end_y),
		.near_end_z     (near_end_z),
		.end_distance   (end_distance)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// an accepted point always goes on to its y step
	a_accept_then_y: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (cmd.mul && cmd.axis == AXIS_Y))
		else $error("accepted point not followed by y step");

	// root load is followed by root steps
	a_root_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_load |=> cmd.root_step)
		else $error("root load not followed by root step");

	// no new point while the roots run or a result is written
	a_no_load_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && (cmd.root_load || cmd.root_step || cmd.out_load)))
		else $error("point loaded during root or result phase");

endmodule
`default_nettype wire

### tb/sv/tb_track_closest_point_finder_top.sv
// Testbench for the track closest point finder: random tracks, running predictor, result checks.
module tb_track_closest_point_finder_top;
	import tcpf_pkg::*;

	// Run bounds. The settle pause between phases covers any point still in
	// flight inside the block.
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PRINT_CAP     = 40;
	localparam int NUM_REFS      = REG_END_Z + 1;

	// The index field is 3 bits wide, so two indexes lie past the register list.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

	localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [COORD_BITS-1:0] COORD_ONE = 24'sd1;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	// One input transaction: a track point and its end-of-track flag.
	typedef struct {
		point_t pt;
		logic   last;
	} track_step_t;

	// One result transaction: nearest point and root distance per reference.
	typedef struct {
		point_t                near_start;
		logic [DIST_BITS-1:0]  start_dist;
		point_t                near_end;
		logic [DIST_BITS-1:0]  end_dist;
	} nearest_pair_t;

	// How a random point is picked, how a set of references is picked, and the
	// receiver's stall behavior.
	typedef enum int {PT_WIDE, PT_NEAR, PT_EDGE, PT_REPEAT} pt_kind_t;
	typedef enum int {REFS_WIDE, REFS_NEAR_ORIGIN, REFS_EDGES, REFS_SHARED} ref_mode_t;
	typedef enum int {RX_FREE, RX_RANDOM, RX_BLOCKS} rx_mode_t;

	// Block ports; every input has a known value from time zero.
	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
	logic [COORD_BITS-1:0]         cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic signed [COORD_BITS-1:0]  step_x    = '0;
	logic signed [COORD_BITS-1:0]  step_y    = '0;
	logic signed [COORD_BITS-1:0]  step_z    = '0;
	logic                          last_step = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [COORD_BITS-1:0]  near_start_x;
	logic signed [COORD_BITS-1:0]  near_start_y;
	logic signed [COORD_BITS-1:0]  near_start_z;
	logic        [DIST_BITS-1:0]   start_distance;
	logic signed [COORD_BITS-1:0]  near_end_x;
	logic signed [COORD_BITS-1:0]  near_end_y;
	logic signed [COORD_BITS-1:0]  near_end_z;
	logic        [DIST_BITS-1:0]   end_distance;

	// Stimulus and expectation stores
	track_step_t   point_q[$];          // points waiting for the driver
	nearest_pair_t expected_nearest_q[$];

	// Predictor copy of the reference registers and the running minima
	logic signed [COORD_BITS-1:0] ref_coord [NUM_REFS] = '{default: '0};
	longint unsigned best_start_dsq = '1;
	longint unsigned best_end_dsq   = '1;
	point_t          best_start_pt  = '{default: '0};
	point_t          best_end_pt    = '{default: '0};

	int       mismatches  = 0;
	int       cycle_count = 0;
	logic     in_taken    = 1'b0;   // input transaction completed at the last edge
	int       burst_left  = 0;
	int       gap_left    = 0;
	rx_mode_t stall_mode  = RX_FREE;
	int       stall_run   = 0;

	track_closest_point_finder_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.step_x         (step_x),
		.step_y         (step_y),
		.step_z         (step_z),
		.last_step      (last_step),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.near_start_x   (near_start_x),
		.near_start_y   (near_start_y),
		.near_start_z   (near_start_z),
		.start_distance (start_distance),
		.near_end_x     (near_end_x),
		.near_end_y     (near_end_y),
		.near_end_z     (near_end_z),
		.end_distance   (end_distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Exact squared distance in 1/256 unit^2; at most 3 * 2^48, so 64 bits hold it.
	function automatic longint unsigned sq_range(point_t p, logic signed [COORD_BITS-1:0] rx,
			logic signed [COORD_BITS-1:0] ry, logic signed [COORD_BITS-1:0] rz);
		longint dx, dy, dz;
		dx = longint'(p.x) - longint'(rx);
		dy = longint'(p.y) - longint'(ry);
		dz = longint'(p.z) - longint'(rz);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// Floor square root, one bit at a time from the top.
	function automatic logic [DIST_BITS-1:0] floor_root(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = DIST_BITS; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r[DIST_BITS-1:0];
	endfunction

	// Fold one accepted point into the minima; a last point closes the track.
	task automatic fold_track_point(track_step_t s);
		longint unsigned d;
		nearest_pair_t   r;
		d = sq_range(s.pt, ref_coord[REG_START_X], ref_coord[REG_START_Y],
			ref_coord[REG_START_Z]);
		// strictly smaller only: the earliest point keeps a tie
		if (d < best_start_dsq) begin
			best_start_dsq = d;
			best_start_pt  = s.pt;
		end
		d = sq_range(s.pt, ref_coord[REG_END_X], ref_coord[REG_END_Y], ref_coord[REG_END_Z]);
		if (d < best_end_dsq) begin
			best_end_dsq = d;
			best_end_pt  = s.pt;
		end
		if (s.last) begin
			r.near_start = best_start_pt;
			r.start_dist = floor_root(best_start_dsq);
			r.near_end   = best_end_pt;
			r.end_dist   = floor_root(best_end_dsq);
			expected_nearest_q.push_back(r);
			best_start_dsq = '1;
			best_end_dsq   = '1;
			best_start_pt  = '{default: '0};
			best_end_pt    = '{default: '0};
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Monitor: outputs are sampled at the rising edge, before the block's own
	// updates land. The result side is handled first so a result and a last
	// point accepted on the same edge never see each other.
	always @(posedge clk) begin
		track_step_t   acc;
		nearest_pair_t want;
		in_taken <= arst_n && in_valid && in_stall === 1'b0;
		if (arst_n) begin
			if (out_valid === 1'b1 && !out_stall) begin
				if (expected_nearest_q.size() == 0) begin
					report_mismatch("result transaction with no finished track waiting");
				end else begin
					want = expected_nearest_q.pop_front();
					compare_field("near_start_x", 32'(near_start_x), 32'(want.near_start.x));
					compare_field("near_start_y", 32'(near_start_y), 32'(want.near_start.y));
					compare_field("near_start_z", 32'(near_start_z), 32'(want.near_start.z));
					compare_field("start_distance", 32'(start_distance), 32'(want.start_dist));
					compare_field("near_end_x", 32'(near_end_x), 32'(want.near_end.x));
					compare_field("near_end_y", 32'(near_end_y), 32'(want.near_end.y));
					compare_field("near_end_z", 32'(near_end_z), 32'(want.near_end.z));
					compare_field("end_distance", 32'(end_distance), 32'(want.end_dist));
				end
			end
			if (in_valid && in_stall === 1'b0) begin
				acc.pt.x = step_x;
				acc.pt.y = step_y;
				acc.pt.z = step_z;
				acc.last = last_step;
				fold_track_point(acc);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver and receiver
	// ------------------------------------------------------------------

	// Sender: bursts of random length with random gaps. A held transaction
	// keeps its payload until the edge that takes it.
	always @(negedge clk) begin
		track_step_t nxt;
		if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (point_q.size() != 0) begin
				nxt = point_q.pop_front();
				step_x    <= nxt.pt.x;
				step_y    <= nxt.pt.y;
				step_z    <= nxt.pt.z;
				last_step <= nxt.last;
				in_valid  <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					// a third of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: free-running, coin-flip, or long blocks of stall; a new mode
	// and a new random run length are drawn each time the current run ends.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 2));
			stall_run  = $urandom_range(20, 200);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			RX_FREE:   out_stall <= 1'b0;
			RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
			default:   out_stall <= ((stall_run / 16) % 2) == 1;
		endcase
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
			logic signed [COORD_BITS-1:0] z, logic last);
		track_step_t s;
		s.pt.x = x;
		s.pt.y = y;
		s.pt.z = z;
		s.last = last;
		point_q.push_back(s);
	endtask

	// Register write; the block is idle whenever this is called.
	task automatic write_ref(logic [CFG_IDX_BITS-1:0] idx, logic signed [COORD_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_END_Z)
			ref_coord[idx] = val;
	endtask

	task automatic load_refs(ref_mode_t mode);
		logic signed [COORD_BITS-1:0] v;
		for (int i = REG_START_X; i <= REG_END_Z; i++) begin
			case (mode)
				REFS_NEAR_ORIGIN: v = COORD_BITS'($urandom_range(0, 512)) - COORD_BITS'(256);
				REFS_EDGES:       v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
				// end reference lands on the start one: both minima track together
				REFS_SHARED:      v = (i > REG_START_Z) ? ref_coord[i - REG_END_X]
				                                        : COORD_BITS'($urandom);
				default:          v = COORD_BITS'($urandom);
			endcase
			write_ref(CFG_IDX_BITS'(i), v);
		end
		if ($urandom_range(0, 1))
			write_ref($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, COORD_BITS'($urandom));
	endtask

	function automatic logic signed [COORD_BITS-1:0] pick_coord(pt_kind_t kind,
			logic signed [COORD_BITS-1:0] centre);
		logic signed [COORD_BITS-1:0] c;
		case (kind)
			PT_NEAR: c = centre + COORD_BITS'($urandom_range(0, 64)) - COORD_BITS'(32);
			PT_EDGE: begin
				case ($urandom_range(0, 4))
					0:       c = COORD_MIN;
					1:       c = COORD_MAX;
					2:       c = '0;
					3:       c = -COORD_ONE;
					default: c = COORD_ONE;
				endcase
			end
			default: c = COORD_BITS'($urandom);
		endcase
		return c;
	endfunction

	// Wait for every point to be taken and every result to come back, then
	// let a last point still inside the block finish.
	task automatic drain_and_settle();
		while (point_q.size() != 0 || in_valid || expected_nearest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Whole tracks with random content: mostly short, a few long. Points are
	// drawn wide, close to a reference (near-ties), at the field edges, or as
	// a repeat of the previous point (exact ties).
	task automatic run_tracks(int budget);
		int       made, len, roll, base;
		pt_kind_t kind;
		point_t   p, prev;
		made = 0;
		prev = '{default: '0};
		while (made < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				roll = $urandom_range(0, 99);
				kind = roll < 40 ? PT_WIDE : roll < 65 ? PT_NEAR : roll < 80 ? PT_EDGE : PT_REPEAT;
				base = $urandom_range(0, 1) ? REG_END_X : REG_START_X;
				if (kind == PT_REPEAT && k > 0) begin
					p = prev;
				end else begin
					p.x = pick_coord(kind, ref_coord[base]);
					p.y = pick_coord(kind, ref_coord[base + 1]);
					p.z = pick_coord(kind, ref_coord[base + 2]);
				end
				push_point(p.x, p.y, p.z, k == len - 1);
				prev = p;
			end
			made += len;
		end
		drain_and_settle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// References at their reset value (origin).
		push_point('0, '0, '0, 1'b1);                      // single point, zero distance
		push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1); // most negative corner
		push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1); // most positive corner
		// three points all 1 unit away: the first must be kept
		push_point(24'sd16, '0, '0, 1'b0);
		push_point('0, -24'sd16, '0, 1'b0);
		push_point('0, '0, 24'sd16, 1'b1);
		// closest point is the last one
		push_point(24'sd100, 24'sd100, 24'sd100, 1'b0);
		push_point(24'sd50, -24'sd3, 24'sd7, 1'b0);
		push_point(COORD_ONE, '0, -COORD_ONE, 1'b1);
		drain_and_settle();

		// References at opposite corners; writes past the list must not land.
		write_ref(REG_START_X, COORD_MAX);
		write_ref(REG_START_Y, COORD_MAX);
		write_ref(REG_START_Z, COORD_MAX);
		write_ref(REG_END_X, COORD_MIN);
		write_ref(REG_END_Y, COORD_MIN);
		write_ref(REG_END_Z, COORD_MIN);
		write_ref(CFG_SPARE_A, COORD_MIN);
		write_ref(CFG_SPARE_B, COORD_MAX);
		push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
		push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1); // largest possible distance
		push_point(COORD_MAX, COORD_MIN, '0, 1'b0);
		push_point('0, COORD_MAX, COORD_MIN, 1'b0);
		push_point(COORD_MIN, '0, COORD_MAX, 1'b1);
		drain_and_settle();

		// Random phases, each under a fresh set of references.
		for (int p = 0; p < 5; p++) begin
			load_refs(ref_mode_t'(p % 4));
			run_tracks(220);
		end

		drain_and_settle();
		if (expected_nearest_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_nearest_q.size()));
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
